>>> hw/rtl/bla_pkg.sv
// Package for the binary lifting level-ancestor engine.
// Holds operation and result codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package bla_pkg;

   localparam int DEPTH_W = 10;
   localparam int INDEX_W = 10;
   localparam int ENTRY_W = INDEX_W + 1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_BUILD = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic load_wr;
      logic dep_rd;
      logic q_eval;
      logic q_step_rd;
      logic q_take;
      logic q_next;
      logic b_init;
      logic b_rd1;
      logic b_rd2;
      logic b_wr;
      logic rsp_build;
      logic rsp_hit;
      logic rsp_miss;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic q_fail;
      logic q_zero;
      logic diff_msb;
      logic walk_last;
      logic jump_valid;
      logic build_last;
   } ctl_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/bla_ctrl.sv
// Controller state machine of the level-ancestor engine.
// Depends on bla_pkg for the command and status structs and the operation codes.
`default_nettype none

module bla_ctrl
   import bla_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [1:0]  req_operation,
   input  var  ctl_sts_type sts,
   output var  ctl_cmd_type cmd,
   output logic             busy
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOAD   = 9'b000000010,
      S_Q_DEP  = 9'b000000100,
      S_Q_EVAL = 9'b000001000,
      S_Q_STEP = 9'b000010000,
      S_Q_TAKE = 9'b000100000,
      S_B_RD1  = 9'b001000000,
      S_B_RD2  = 9'b010000000,
      S_B_WR   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_operation)
                  OP_LOAD:  state_in = S_LOAD;
                  OP_BUILD: begin
                     cmd.b_init = 1'b1;
                     state_in   = S_B_RD1;
                  end
                  OP_QUERY: state_in = S_Q_DEP;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_Q_DEP: begin
            cmd.dep_rd = 1'b1;
            state_in   = S_Q_EVAL;
         end
         S_Q_EVAL: begin
            if (sts.q_fail) begin
               cmd.rsp_miss = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.q_zero) begin
               cmd.rsp_hit = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.q_eval = 1'b1;
               state_in   = S_Q_STEP;
            end
         end
         S_Q_STEP: begin
            if (sts.diff_msb) begin
               cmd.q_step_rd = 1'b1;
               state_in      = S_Q_TAKE;
            end else begin
               cmd.q_next = 1'b1;
               if (sts.walk_last) begin
                  cmd.rsp_hit = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_Q_TAKE: begin
            if (!sts.jump_valid) begin
               cmd.rsp_miss = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.q_take = 1'b1;
               cmd.q_next = 1'b1;
               if (sts.walk_last) begin
                  cmd.rsp_hit = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_Q_STEP;
               end
            end
         end
         S_B_RD1: begin
            cmd.b_rd1 = 1'b1;
            state_in  = S_B_RD2;
         end
         S_B_RD2: begin
            cmd.b_rd2 = 1'b1;
            state_in  = S_B_WR;
         end
         S_B_WR: begin
            cmd.b_wr = 1'b1;
            if (sts.build_last) begin
               cmd.rsp_build = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_B_RD1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bla_dpath.sv
// Datapath of the level-ancestor engine: jump table and depth memories,
// walk and sweep counters, and the result register. Depends on bla_pkg.
`default_nettype none

module bla_dpath
   import bla_pkg::*;
#(
   parameter int NODES       = 1024,
   parameter int JUMP_LEVELS = 11
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [INDEX_W-1:0] req_node,
   input  wire logic [INDEX_W-1:0] req_parent,
   input  wire logic               req_has_parent,
   input  wire logic [DEPTH_W-1:0] req_depth,
   input  wire logic [DEPTH_W-1:0] req_target_level,
   input  var  ctl_cmd_type        cmd,
   output var  ctl_sts_type        sts,
   output logic                    rsp_valid,
   output logic                    rsp_result_kind,
   output logic [INDEX_W-1:0]      rsp_ancestor,
   output logic                    rsp_found
);

   // Node indices are 10 bits wide, so no more than 1024 entries per level are reachable.
   localparam int NODE_CNT   = (NODES < (1 << INDEX_W)) ? NODES : (1 << INDEX_W);
   localparam int NODE_W     = $clog2(NODE_CNT);
   localparam int LVL_W      = $clog2(JUMP_LEVELS);
   localparam int JMEM_DEPTH = JUMP_LEVELS * NODE_CNT;
   localparam int ADDR_W     = $clog2(JMEM_DEPTH);
   localparam int WALK_BITS  = (JUMP_LEVELS < DEPTH_W) ? JUMP_LEVELS : DEPTH_W;

   logic [ENTRY_W-1:0] jump_mem [JMEM_DEPTH];
   logic [DEPTH_W-1:0] depth_mem [NODE_CNT];

   logic [INDEX_W-1:0]   node_ff, parent_ff, u_ff, u_in;
   logic                 has_parent_ff;
   logic [DEPTH_W-1:0]   depth_ff, target_ff, dep_q_ff;
   logic                 node_ok_ff;
   logic [ENTRY_W-1:0]   jmem_q_ff;
   logic                 ev_ff;
   logic [WALK_BITS-1:0] diff_ff, diff_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [NODE_W-1:0]    v_ff, v_in;

   logic                 rsp_valid_ff, rsp_kind_ff, rsp_found_ff;
   logic [INDEX_W-1:0]   rsp_anc_ff, anc_in;

   logic [DEPTH_W:0]     diff_full;
   logic [DEPTH_W-1:0]   diff_w;
   logic                 too_wide;
   logic                 v_last;
   logic [ADDR_W-1:0]    prev_base;
   logic [ADDR_W-1:0]    jm_raddr;
   logic                 jm_re;
   logic [ADDR_W-1:0]    jm_waddr;
   logic [ENTRY_W-1:0]   jm_wdata;
   logic                 jm_we;
   logic                 parent_ok;

   assign diff_full = {1'b0, dep_q_ff} - {1'b0, target_ff};
   assign diff_w    = diff_full[DEPTH_W-1:0];
   assign too_wide  = ((diff_w >> WALK_BITS) != '0);
   assign v_last    = (v_ff == NODE_W'(NODE_CNT - 1));
   assign prev_base = base_ff - ADDR_W'(NODE_CNT);
   assign parent_ok = has_parent_ff && (32'(parent_ff) < NODES);

   assign sts.q_fail     = !node_ok_ff || diff_full[DEPTH_W] || too_wide;
   assign sts.q_zero     = (diff_w == '0);
   assign sts.diff_msb   = diff_ff[WALK_BITS-1];
   assign sts.walk_last  = (lvl_ff == '0);
   assign sts.jump_valid = jmem_q_ff[ENTRY_W-1];
   assign sts.build_last = v_last && (lvl_ff == LVL_W'(JUMP_LEVELS - 1));

   // Jump table address selection.
   always_comb begin
      jm_re    = 1'b1;
      jm_raddr = base_ff + ADDR_W'(u_ff[NODE_W-1:0]);
      if (cmd.b_rd1) begin
         jm_raddr = prev_base + ADDR_W'(v_ff);
      end else if (cmd.b_rd2) begin
         jm_raddr = prev_base + ADDR_W'(jmem_q_ff[NODE_W-1:0]);
      end else if (!cmd.q_step_rd) begin
         jm_re = 1'b0;
      end
   end

   always_comb begin
      jm_we    = 1'b0;
      jm_waddr = ADDR_W'(node_ff[NODE_W-1:0]);
      jm_wdata = parent_ok ? {1'b1, parent_ff} : '0;
      if (cmd.load_wr) begin
         jm_we = node_ok_ff;
      end else if (cmd.b_wr) begin
         jm_we    = 1'b1;
         jm_waddr = base_ff + ADDR_W'(v_ff);
         jm_wdata = ev_ff ? jmem_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (jm_we) begin
         jump_mem[jm_waddr] <= jm_wdata;
      end
      if (jm_re) begin
         jmem_q_ff <= jump_mem[jm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && node_ok_ff) begin
         depth_mem[node_ff[NODE_W-1:0]] <= depth_ff;
      end
      if (cmd.dep_rd) begin
         dep_q_ff <= depth_mem[node_ff[NODE_W-1:0]];
      end
   end

   // Walk and sweep counters.
   always_comb begin
      diff_in = diff_ff;
      lvl_in  = lvl_ff;
      base_in = base_ff;
      v_in    = v_ff;
      u_in    = u_ff;
      if (cmd.capture) begin
         u_in = req_node;
      end
      if (cmd.q_take) begin
         u_in = jmem_q_ff[INDEX_W-1:0];
      end
      if (cmd.q_eval) begin
         diff_in = diff_w[WALK_BITS-1:0];
         lvl_in  = LVL_W'(WALK_BITS - 1);
         base_in = ADDR_W'((WALK_BITS - 1) * NODE_CNT);
      end
      if (cmd.q_next) begin
         diff_in = diff_ff << 1;
         lvl_in  = lvl_ff - LVL_W'(1);
         base_in = base_ff - ADDR_W'(NODE_CNT);
      end
      if (cmd.b_init) begin
         lvl_in  = LVL_W'(1);
         base_in = ADDR_W'(NODE_CNT);
         v_in    = '0;
      end
      if (cmd.b_wr) begin
         if (v_last) begin
            v_in    = '0;
            lvl_in  = lvl_ff + LVL_W'(1);
            base_in = base_ff + ADDR_W'(NODE_CNT);
         end else begin
            v_in = v_ff + NODE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      lvl_ff  <= lvl_in;
      base_ff <= base_in;
      v_ff    <= v_in;
      u_ff    <= u_in;
      if (cmd.b_rd2) begin
         ev_ff <= jmem_q_ff[ENTRY_W-1];
      end
      if (cmd.capture) begin
         node_ff       <= req_node;
         parent_ff     <= req_parent;
         has_parent_ff <= req_has_parent;
         depth_ff      <= req_depth;
         target_ff     <= req_target_level;
         node_ok_ff    <= (32'(req_node) < NODES);
      end
   end

   // Result register.
   always_comb begin
      anc_in = '0;
      if (cmd.rsp_hit) begin
         anc_in = cmd.q_take ? jmem_q_ff[INDEX_W-1:0] : u_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_build || cmd.rsp_hit || cmd.rsp_miss;
      end
      rsp_kind_ff  <= cmd.rsp_build ? KIND_BUILD : KIND_QUERY;
      rsp_found_ff <= cmd.rsp_hit;
      rsp_anc_ff   <= anc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_ancestor    = rsp_anc_ff;
   assign rsp_found       = rsp_found_ff;

endmodule

`default_nettype wire

>>> hw/rtl/binary_lifting_level_ancestor.sv
// Top level of the binary lifting level-ancestor engine.
// Instantiates bla_ctrl and bla_dpath; depends on bla_pkg.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_operation, req_node, req_parent,
//                                                req_has_parent, req_depth, req_target_level
// response  out        rsp_valid for one cycle   rsp_result_kind, rsp_ancestor, rsp_found
//
// A load beat writes the node's level-0 jump entry and its depth. A query beat ends after
// the depth read when the node is out of range, the target is deeper than the node or
// equal to its depth, or the climb does not fit the table. Otherwise it walks up to
// min(JUMP_LEVELS, 10) jump levels, as a 10-bit depth difference needs no more, and
// stops with a miss at an empty jump entry; each jump taken needs one read of the jump
// table, which has a single read port. A build beat sweeps every upper level of the
// table, min(NODES, 1024) entries per level, and for each entry reads the entry one
// level down, reads the entry that it points to, and writes the new jump.
// Reset is synchronous and returns the controller to idle; the memories are not
// cleared and must be written before they are read. The receiver cannot stall:
// each result is shown for exactly one cycle, the first cycle after busy falls.
`default_nettype none

module binary_lifting_level_ancestor
   import bla_pkg::*;
#(
   parameter int NODES       = 1024,
   parameter int JUMP_LEVELS = 11
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic [INDEX_W-1:0] req_node,
   input  wire logic [INDEX_W-1:0] req_parent,
   input  wire logic               req_has_parent,
   input  wire logic [DEPTH_W-1:0] req_depth,
   input  wire logic [DEPTH_W-1:0] req_target_level,
   output logic                    rsp_valid,
   output logic                    rsp_result_kind,
   output logic [INDEX_W-1:0]      rsp_ancestor,
   output logic                    rsp_found
);

   // The controller sequences loads, queries and the build sweep; the datapath
   // owns every register and memory that holds data.
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   bla_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy)
   );

   // The datapath captures the request fields when a beat is accepted, so the
   // request ports may change freely while the block is busy.
   bla_dpath #(
      .NODES       (NODES),
      .JUMP_LEVELS (JUMP_LEVELS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_node         (req_node),
      .req_parent       (req_parent),
      .req_has_parent   (req_has_parent),
      .req_depth        (req_depth),
      .req_target_level (req_target_level),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_ancestor     (rsp_ancestor),
      .rsp_found        (rsp_found)
   );

endmodule

`default_nettype wire

>>> hw/rtl/bla_checker.sv
// Port-level checker for the level-ancestor engine, bound to the top level.
// Depends on bla_pkg for the operation and result codes.
`default_nettype none

module bla_checker
   import bla_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [1:0]         req_operation,
   input wire logic               rsp_valid,
   input wire logic               rsp_result_kind,
   input wire logic [INDEX_W-1:0] rsp_ancestor,
   input wire logic               rsp_found
);

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while the block is still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_LOAD)) |=> !rsp_valid)
      else $error("a load beat produced a result");

   a_work_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_operation == OP_BUILD) || (req_operation == OP_QUERY)))
      |=> busy)
      else $error("a build or query beat did not make the block busy");

   a_build_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_BUILD)) |-> (!rsp_found && (rsp_ancestor == '0)))
      else $error("build result carries an ancestor");

endmodule

bind binary_lifting_level_ancestor bla_checker u_bla_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_result_kind (rsp_result_kind),
   .rsp_ancestor    (rsp_ancestor),
   .rsp_found       (rsp_found)
);

`default_nettype wire
